// ----- rtl/core/fmt_pkg.sv -----
// shared constants, codes and controller/datapath bundles of the fact mutex table
`default_nettype none
package fmt_pkg;

	// fact indexes and pair matrix geometry
	localparam int FACT_W    = 6;
	localparam int FACTS     = 1 << FACT_W;
	localparam int NUM_FACTS = 64;

	// large-set store
	localparam int MAX_LARGE = 16;
	localparam int LCNT_W    = $clog2(MAX_LARGE + 1);
	localparam int LIDX_W    = (MAX_LARGE > 1) ? $clog2(MAX_LARGE) : 1;

	// distinct-fact count of a set saturates at the large-set threshold
	localparam int LARGE_MIN = 3;
	localparam int CNT_W     = $clog2(LARGE_MIN + 1);

	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_LARGE = CNT_W'(LARGE_MIN);

	// operation codes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic take;         // capture input item, read its matrix row
		logic merge;        // fold the fetched row and fact into the set
		logic rd_a;         // read row of first fact
		logic rd_b;         // read row of second fact
		logic wr_a;         // write back row of first fact
		logic wr_b;         // write back row of second fact
		logic store_large;  // put the set into the large-set store
		logic scan_clr;     // restart the large-set scan
		logic scan_step;    // test one stored large set
		logic finish;       // load result register, clear the set
	} fmt_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic              last;
		logic              op;
		logic              pair_hit;
		logic              has_large;
		logic              large_zero;
		logic [CNT_W-1:0]  cnt;
		logic              sub_hit;
		logic              scan_end;
		logic              out_free;
		logic [LCNT_W-1:0] large_cnt;
	} fmt_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/fmt_in_if.sv -----
// input channel: one fact of a set per transfer
`default_nettype none
interface fmt_in_if
	import fmt_pkg::*;
;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [FACT_W-1:0] fact;
	logic              last;

	modport source (output valid, output operation, output fact, output last, input ready);
	modport sink (input valid, input operation, input fact, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/fmt_out_if.sv -----
// output channel: one result per completed set
`default_nettype none
interface fmt_out_if;
	logic valid;
	logic ready;
	logic kind;
	logic is_mutex;
	logic store_full;

	modport source (output valid, output kind, output is_mutex, output store_full, input ready);
	modport sink (input valid, input kind, input is_mutex, input store_full, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/fact_mutex_table_top.sv -----
// top level of the fact mutex table: controller, datapath and checks
// a fact that does not end its set: transfer with its matrix row read, then the merge into the set
// a query decides after its last fact, scanning the stored large sets unless a pair hit settles it
// an add of one or two facts reads and writes back the matrix row of each of them
// an add of three or more facts goes to the large-set store; results wait in one output register
// asynchronous reset clears control state and the matrix row valid bits at once
`default_nettype none
module fact_mutex_table_top
	import fmt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	fmt_in_if.sink    req,
	fmt_out_if.source rsp
);

	fmt_cmd_t cmd;
	fmt_sts_t sts;
	logic     in_ready;

	assign req.ready = in_ready;

	// sequencing
	fmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and set logic
	fmt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_operation   (req.operation),
		.in_fact        (req.fact),
		.in_last        (req.last),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.out_kind       (rsp.kind),
		.out_is_mutex   (rsp.is_mutex),
		.out_store_full (rsp.store_full)
	);

	// one item at a time: no transfer in the cycle after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("input accepted while previous item still in work");

	// a dropped large set only happens with a full store
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.store_full) |-> (sts.large_cnt == LCNT_W'(MAX_LARGE)))
		else $error("store_full reported with room left");

	// store count never runs past its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.large_cnt <= LCNT_W'(MAX_LARGE))
		else $error("large-set count overflow");

	// query answers never carry store_full, add results never carry is_mutex
	a_res_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.kind == OP_QUERY) ? !rsp.store_full : !rsp.is_mutex))
		else $error("result field does not fit result kind");

endmodule
`default_nettype wire

// ----- rtl/core/fmt_dp.sv -----
// datapath: pair matrix memory, large-set store, set gathering and result register
`default_nettype none
module fmt_dp
	import fmt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fmt_cmd_t          cmd,
	output fmt_sts_t               sts,
	input  wire logic              in_operation,
	input  wire logic [FACT_W-1:0] in_fact,
	input  wire logic              in_last,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   out_kind,
	output logic                   out_is_mutex,
	output logic                   out_store_full
);

	// pair matrix rows with per-row valid bits; an invalid row reads as zero
	logic [FACTS-1:0] mat_mem [FACTS];
	logic [FACTS-1:0] mat_vld_q;
	logic [FACTS-1:0] rd_data_q;
	logic             rd_vld_q;

	// large-set store
	logic [FACTS-1:0]  large_mem [MAX_LARGE];
	logic [LCNT_W-1:0] large_cnt_q;
	logic              has_large_q;
	logic [LIDX_W-1:0] scan_idx_q;
	logic [FACTS-1:0]  scan_set_q;

	// item and set registers
	logic              op_q;
	logic [FACT_W-1:0] fact_q;
	logic              last_q;
	logic [FACTS-1:0]  pend_q;
	logic              pair_hit_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FACT_W-1:0] fa_q;
	logic [FACT_W-1:0] fb_q;
	logic              scan_hit_q;
	logic              full_q;

	// result register
	logic out_valid_q;
	logic out_kind_q;
	logic out_mutex_q;
	logic out_full_q;

	logic              rd_en;
	logic [FACT_W-1:0] rd_addr;
	logic              wr_en;
	logic [FACT_W-1:0] wr_addr;
	logic [FACTS-1:0]  wr_data;
	logic [FACTS-1:0]  row;
	logic [FACTS-1:0]  fbit;
	logic              fact_in;
	logic              ab_ok;
	logic              room;
	logic [FACTS-1:0]  scan_set;

	function automatic logic in_mat(input logic [FACT_W-1:0] f);
		return {1'b0, f} < (FACT_W + 1)'(NUM_FACTS);
	endfunction

	// fetched row, masked by its valid bit
	assign row     = rd_vld_q ? rd_data_q : '0;
	assign fbit    = FACTS'(1) << fact_q;
	assign fact_in = in_mat(fact_q);
	assign ab_ok   = (cnt_q == CNT_TWO) ? (in_mat(fa_q) && in_mat(fb_q)) : in_mat(fa_q);
	assign room    = large_cnt_q < LCNT_W'(MAX_LARGE);

	// matrix port selection
	always_comb begin
		rd_en   = cmd.take | cmd.rd_a | cmd.rd_b;
		rd_addr = in_fact;
		if (cmd.rd_a) begin
			rd_addr = fa_q;
		end else if (cmd.rd_b) begin
			rd_addr = fb_q;
		end
		wr_en   = (cmd.wr_a | cmd.wr_b) & ab_ok;
		wr_addr = fa_q;
		wr_data = row | (FACTS'(1) << ((cnt_q == CNT_TWO) ? fb_q : fa_q));
		if (cmd.wr_b) begin
			wr_addr = fb_q;
			wr_data = row | (FACTS'(1) << fa_q);
		end
	end

	// matrix memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mat_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mat_mem[rd_addr];
		end
	end

	// row valid bits and registered valid of the read row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				mat_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= mat_vld_q[rd_addr];
			end
		end
	end

	// large-set store writes, registered read one entry ahead of the scan
	always_ff @(posedge clk) begin
		if (cmd.store_large && room) begin
			large_mem[large_cnt_q[LIDX_W-1:0]] <= pend_q;
		end
		if (cmd.scan_clr) begin
			scan_set_q <= large_mem[LIDX_W'(0)];
		end else if (cmd.scan_step) begin
			scan_set_q <= large_mem[scan_idx_q + LIDX_W'(1)];
		end
	end

	assign scan_set = scan_set_q;

	// captured input item
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= in_operation;
			fact_q <= in_fact;
			last_q <= in_last;
		end
	end

	// set gathering, store bookkeeping and scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			pair_hit_q  <= 1'b0;
			cnt_q       <= '0;
			fa_q        <= '0;
			fb_q        <= '0;
			scan_hit_q  <= 1'b0;
			full_q      <= 1'b0;
			large_cnt_q <= '0;
			has_large_q <= 1'b0;
			scan_idx_q  <= '0;
		end else begin
			if (cmd.merge) begin
				if (fact_in && ((row & (pend_q | fbit)) != '0)) begin
					pair_hit_q <= 1'b1;
				end
				if (!pend_q[fact_q]) begin
					if (cnt_q == '0) begin
						fa_q <= fact_q;
					end
					if (cnt_q == CNT_ONE) begin
						fb_q <= fact_q;
					end
					if (cnt_q != CNT_LARGE) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				pend_q <= pend_q | fbit;
			end
			if (cmd.store_large) begin
				has_large_q <= 1'b1;
				if (room) begin
					large_cnt_q <= large_cnt_q + LCNT_W'(1);
				end else begin
					full_q <= 1'b1;
				end
			end
			if (cmd.scan_clr) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + LIDX_W'(1);
				if ((scan_set & ~pend_q) == '0) begin
					scan_hit_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				pend_q     <= '0;
				pair_hit_q <= 1'b0;
				cnt_q      <= '0;
				scan_hit_q <= 1'b0;
				full_q     <= 1'b0;
			end
		end
	end

	// result register, freed by a transfer on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_kind_q  <= op_q;
			out_mutex_q <= (op_q == OP_QUERY) && (pair_hit_q || scan_hit_q);
			out_full_q  <= (op_q == OP_ADD) && full_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = out_kind_q;
	assign out_is_mutex   = out_mutex_q;
	assign out_store_full = out_full_q;

	// status toward the controller
	always_comb begin
		sts.last       = last_q;
		sts.op         = op_q;
		sts.pair_hit   = pair_hit_q;
		sts.has_large  = has_large_q;
		sts.large_zero = (large_cnt_q == '0);
		sts.cnt        = cnt_q;
		sts.sub_hit    = (scan_set & ~pend_q) == '0;
		sts.scan_end   = ({1'b0, scan_idx_q} + (LIDX_W + 1)'(1)) >= (LIDX_W + 1)'(large_cnt_q);
		sts.out_free   = !out_valid_q || out_ready;
		sts.large_cnt  = large_cnt_q;
	end

endmodule
`default_nettype wire

// ----- rtl/core/fmt_ctrl.sv -----
// controller: sequences fact lookup, set completion, store scan and matrix updates
`default_nettype none
module fmt_ctrl
	import fmt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire fmt_sts_t sts,
	output fmt_cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LOOK   = 4'd1;
	localparam logic [3:0] ST_DECIDE = 4'd2;
	localparam logic [3:0] ST_SCAN   = 4'd3;
	localparam logic [3:0] ST_RD_A   = 4'd4;
	localparam logic [3:0] ST_WR_A   = 4'd5;
	localparam logic [3:0] ST_RD_B   = 4'd6;
	localparam logic [3:0] ST_WR_B   = 4'd7;
	localparam logic [3:0] ST_RESULT = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.merge = 1'b1;
				state_d   = sts.last ? ST_DECIDE : ST_IDLE;
			end
			ST_DECIDE: begin
				if (sts.op == OP_QUERY) begin
					if (sts.pair_hit || !sts.has_large || sts.large_zero) begin
						state_d = ST_RESULT;
					end else begin
						cmd.scan_clr = 1'b1;
						state_d      = ST_SCAN;
					end
				end else if (sts.cnt == CNT_LARGE) begin
					cmd.store_large = 1'b1;
					state_d         = ST_RESULT;
				end else if (sts.cnt inside {CNT_ONE, CNT_TWO}) begin
					state_d = ST_RD_A;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.sub_hit || sts.scan_end) begin
					state_d = ST_RESULT;
				end
			end
			ST_RD_A: begin
				cmd.rd_a = 1'b1;
				state_d  = ST_WR_A;
			end
			ST_WR_A: begin
				cmd.wr_a = 1'b1;
				state_d  = (sts.cnt == CNT_TWO) ? ST_RD_B : ST_RESULT;
			end
			ST_RD_B: begin
				cmd.rd_b = 1'b1;
				state_d  = ST_WR_B;
			end
			ST_WR_B: begin
				cmd.wr_b = 1'b1;
				state_d  = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- dv/fact_mutex_table_top_test.sv -----
// testbench of the fact mutex table: set stimulus, answer prediction and checks
module fact_mutex_table_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fmt_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int ITEM_COUNT  = 1500;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 40;

	typedef struct packed {
		logic kind;
		logic is_mutex;
		logic store_full;
	} answer_t;

	// mirrors the pair matrix and large-set store, queues the answers each set should give
	class mutex_tracker;
		logic [FACTS-1:0] pair_rows [FACTS];
		logic [FACTS-1:0] large_masks [MAX_LARGE];
		int unsigned      large_used;
		bit               large_seen;
		logic [FACTS-1:0] open_mask;
		bit               open_hit;
		answer_t          answers_due [$];
		int unsigned      mismatches;
		int unsigned      answers_checked;
		int unsigned      facts_taken;
		int unsigned      adds_done;
		int unsigned      queries_done;
		int unsigned      mutex_answers;
		int unsigned      drops;

		function new();
			foreach (pair_rows[i]) pair_rows[i] = '0;
			foreach (large_masks[i]) large_masks[i] = '0;
			large_used      = 0;
			large_seen      = 0;
			open_mask       = '0;
			open_hit        = 0;
			mismatches      = 0;
			answers_checked = 0;
			facts_taken     = 0;
			adds_done       = 0;
			queries_done    = 0;
			mutex_answers   = 0;
			drops           = 0;
		endfunction

		function void flag_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("[%0t] mismatch: %s", $time, msg);
			end
		endfunction

		// fold one accepted fact into the open set; a last fact closes it
		function void take_fact(logic op, logic [FACT_W-1:0] f, logic lst);
			logic [FACTS-1:0] f_bit;
			answer_t          due;
			int               first_idx;
			int               second_idx;
			int               n;
			f_bit    = '0;
			f_bit[f] = 1'b1;
			facts_taken++;
			// one matrix row read per fact, diagonal included
			if (int'(f) < NUM_FACTS && (pair_rows[f] & (open_mask | f_bit)) != '0) begin
				open_hit = 1;
			end
			open_mask |= f_bit;
			if (!lst) begin
				return;
			end

			due.kind       = op;
			due.is_mutex   = 1'b0;
			due.store_full = 1'b0;
			if (op == OP_QUERY) begin
				// pair hit, else any stored large set fully inside the query
				due.is_mutex = open_hit;
				if (!open_hit && large_seen) begin
					for (int k = 0; k < large_used; k++) begin
						if ((large_masks[k] & ~open_mask) == '0) begin
							due.is_mutex = 1'b1;
						end
					end
				end
				queries_done++;
				if (due.is_mutex) begin
					mutex_answers++;
				end
			end else begin
				n          = $countones(open_mask);
				first_idx  = -1;
				second_idx = -1;
				for (int i = 0; i < FACTS; i++) begin
					if (open_mask[i]) begin
						if (first_idx < 0) begin
							first_idx = i;
						end else if (second_idx < 0) begin
							second_idx = i;
						end
					end
				end
				if (n >= LARGE_MIN) begin
					// large set goes to the store, or is dropped when it is full
					large_seen = 1;
					if (large_used < MAX_LARGE) begin
						large_masks[large_used] = open_mask;
						large_used++;
					end else begin
						due.store_full = 1'b1;
						drops++;
					end
				end else if (n == 2) begin
					if (first_idx < NUM_FACTS && second_idx < NUM_FACTS) begin
						pair_rows[first_idx][second_idx] = 1'b1;
						pair_rows[second_idx][first_idx] = 1'b1;
					end
				end else if (n == 1) begin
					if (first_idx < NUM_FACTS) begin
						pair_rows[first_idx][first_idx] = 1'b1;
					end
				end
				adds_done++;
			end
			answers_due.push_back(due);
			open_mask = '0;
			open_hit  = 0;
		endfunction

		// compare one result transfer with the oldest answer due
		function void check_answer(logic kind, logic is_mutex, logic store_full);
			answer_t want;
			answers_checked++;
			if (answers_due.size() == 0) begin
				flag_mismatch($sformatf("result with none due: kind %0d is_mutex %0d store_full %0d",
					kind, is_mutex, store_full));
				return;
			end
			want = answers_due.pop_front();
			if (kind !== want.kind || is_mutex !== want.is_mutex
					|| store_full !== want.store_full) begin
				flag_mismatch($sformatf(
					"expected kind %0d is_mutex %0d store_full %0d, got kind %0d is_mutex %0d store_full %0d",
					want.kind, want.is_mutex, want.store_full, kind, is_mutex, store_full));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fmt_in_if  req_if ();
	fmt_out_if rsp_if ();

	fact_mutex_table_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	mutex_tracker sb = new();

	logic [FACT_W-1:0] set_facts [$];
	logic [FACTS-1:0]  set_bits;
	int unsigned       items_sent;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one fact transfer, with random gaps outside the steady window
	task automatic send_item(input logic op, input logic [FACT_W-1:0] f, input logic lst);
		if (items_sent < 300 || items_sent >= 600) begin
			while ($urandom_range(99) < 31) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_if.valid     <= 1'b1;
		req_if.operation <= op;
		req_if.fact      <= f;
		req_if.last      <= lst;
		@(posedge clk);
		while (req_if.ready !== 1'b1) @(posedge clk);
		sb.take_fact(op, f, lst);
		items_sent++;
	endtask

	// send the gathered facts; earlier operation bits are random, the last one decides
	task automatic send_set(input logic op);
		int cnt;
		cnt = set_facts.size();
		for (int i = 0; i < cnt; i++) begin
			if (i == cnt - 1) begin
				send_item(op, set_facts[i], 1'b1);
			end else begin
				send_item(1'($urandom_range(1)), set_facts[i], 1'b0);
			end
		end
	endtask

	// lower valid and wait until every answer due has come back
	task automatic drain_answers();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (sb.answers_due.size() != 0);
	endtask

	function automatic void add_distinct(int n);
		logic [FACT_W-1:0] f;
		int                added;
		added = 0;
		while (added < n) begin
			f = FACT_W'($urandom_range(FACTS - 1));
			if (!set_bits[f]) begin
				set_bits[f] = 1'b1;
				set_facts.push_back(f);
				added++;
			end
		end
	endfunction

	// build one random set: mostly well-formed adds and queries, some noise
	task automatic random_set();
		int                r;
		int                k;
		logic              op;
		logic [FACTS-1:0]  mask;
		logic [FACT_W-1:0] swap;
		set_facts.delete();
		set_bits = '0;
		op = OP_ADD;
		r  = $urandom_range(99);
		if (r < 4) begin
			add_distinct(1);
		end else if (r < 30) begin
			add_distinct(2);
		end else if (r < 50) begin
			add_distinct($urandom_range(5, 3));
		end else if (r < 90) begin
			op = OP_QUERY;
			if (sb.large_used != 0 && $urandom_range(3) == 0) begin
				// superset of a stored large set
				mask = sb.large_masks[$urandom_range(sb.large_used - 1)];
				for (int i = 0; i < FACTS; i++) begin
					if (mask[i]) begin
						set_bits[i] = 1'b1;
						set_facts.push_back(FACT_W'(i));
					end
				end
				add_distinct($urandom_range(2));
			end else begin
				add_distinct($urandom_range(6, 1));
			end
		end else begin
			// noise: any op, any facts, repeats allowed
			op = 1'($urandom_range(1));
			repeat ($urandom_range(8, 1)) set_facts.push_back(FACT_W'($urandom_range(FACTS - 1)));
		end
		// repeated fact, then shuffle the order
		if ($urandom_range(4) == 0) begin
			set_facts.push_back(set_facts[$urandom_range(set_facts.size() - 1)]);
		end
		for (int i = set_facts.size() - 1; i > 0; i--) begin
			k            = $urandom_range(i);
			swap         = set_facts[i];
			set_facts[i] = set_facts[k];
			set_facts[k] = swap;
		end
		send_set(op);
	endtask

	// stimulus and end of run
	initial begin
		bit paused;
		paused     = 0;
		items_sent = 0;
		arst_n           <= 1'b0;
		req_if.valid     <= 1'b0;
		req_if.operation <= OP_ADD;
		req_if.fact      <= '0;
		req_if.last      <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, diagonal, merged pair, large subset
		set_facts = '{6'd0};
		send_set(OP_QUERY);
		set_facts = '{6'd63};
		send_set(OP_ADD);
		set_facts = '{6'd63};
		send_set(OP_QUERY);
		set_facts = '{6'd0, 6'd0, 6'd5};
		send_set(OP_ADD);
		set_facts = '{6'd5, 6'd0};
		send_set(OP_QUERY);
		set_facts = '{6'd1, 6'd2, 6'd3};
		send_set(OP_ADD);
		set_facts = '{6'd4, 6'd3, 6'd2, 6'd1};
		send_set(OP_QUERY);
		set_facts = '{6'd1, 6'd2};
		send_set(OP_QUERY);
		drain_answers();

		// random sets, with one pause until all answers are back
		while (items_sent < ITEM_COUNT) begin
			if (!paused && items_sent >= 1000) begin
				paused = 1;
				drain_answers();
			end
			random_set();
		end
		drain_answers();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d fact transfers in %0d sets: %0d adds, %0d dropped on a full store",
			sb.facts_taken, sb.adds_done + sb.queries_done, sb.adds_done, sb.drops);
		$display("%0d queries, %0d answered mutex; %0d of %0d large slots used; %0d mismatches",
			sb.queries_done, sb.mutex_answers, sb.large_used, MAX_LARGE, sb.mismatches);
		if (sb.mismatches == 0 && sb.answers_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// result side: checks each transfer, random stalls, a window of steady ready, one long hold-off
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				sb.check_answer(rsp_if.kind, rsp_if.is_mutex, rsp_if.store_full);
			end
			if (!hold_done && sb.answers_checked >= 250) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (sb.answers_checked >= 100 && sb.answers_checked < 180) begin
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= 31);
			end
		end
	end

	// watchdog: too long without any transfer ends the run
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid === 1'b1 && req_if.ready === 1'b1)
					|| (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

endmodule
